// File: hdl/oms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oms_pkg
// Types, field widths and helpers shared by the onset meter / swing blocks.
// ----------------------------------------------------------------------------
package oms_pkg;

  localparam int POS_W   = 48;
  localparam int STR_W   = 16;
  localparam int PER_W   = 32;
  localparam int METER_W = 3;
  localparam int SWING_W = 16;
  localparam int BIN_W   = 8;
  localparam int MIN_METER_ENTRIES = 8;
  localparam int MIN_SWING_ENTRIES = 4;

  localparam logic [METER_W-1:0] METER_TWO   = 3'd2;
  localparam logic [METER_W-1:0] METER_THREE = 3'd3;
  localparam logic [METER_W-1:0] METER_FOUR  = 3'd4;
  localparam logic [METER_W-1:0] METER_SIX   = 3'd6;

  localparam logic signed [SWING_W-1:0] SWING_MAX = 16'sh7FFF;
  localparam logic signed [SWING_W-1:0] SWING_MIN = 16'sh8000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LAT,
    ST_DIV_BIN,
    ST_DIV_PH,
    ST_SW_MUL,
    ST_SW_SUB,
    ST_SW_GO,
    ST_SW_DIV,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    DSEL_BIN,
    DSEL_PHASE,
    DSEL_SWING
  } div_sel_t;

  // base-4 digit sum keeps the residue mod 3
  function automatic logic mod3_zero(input logic [BIN_W-1:0] b);
    logic [3:0] s;
    s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
    return (s == 4'd0) || (s == 4'd3) || (s == 4'd6) || (s == 4'd9) || (s == 4'd12);
  endfunction

endpackage

// File: hdl/oms_onset_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oms_onset_if
// Onset channel: position, strength and beat period with valid/ready.
// ----------------------------------------------------------------------------
interface oms_onset_if
  import oms_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] onset_pos;
  logic [STR_W-1:0] onset_strength;
  logic [PER_W-1:0] beat_period;

  modport source (output valid, onset_pos, onset_strength, beat_period, input ready);
  modport sink   (input valid, onset_pos, onset_strength, beat_period, output ready);
endinterface

// File: hdl/oms_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oms_result_if
// Result channel: meter numerator, swing and update flag with valid/ready.
// ----------------------------------------------------------------------------
interface oms_result_if
  import oms_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [METER_W-1:0]        meter_num;
  logic signed [SWING_W-1:0] swing;
  logic                      meter_updated;

  modport source (output valid, meter_num, swing, meter_updated, input ready);
  modport sink   (input valid, meter_num, swing, meter_updated, output ready);
endinterface

// File: hdl/oms_hist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oms_hist_mem
// Onset history store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module oms_hist_mem
  import oms_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [POS_W-1:0] wpos,
  input  logic [STR_W-1:0] wstr,
  input  logic [AW-1:0]    raddr,
  output logic [POS_W-1:0] rpos,
  output logic [STR_W-1:0] rstr
);

  logic [POS_W+STR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wpos, wstr};
    end
  end

  always_ff @(posedge clk) begin
    {rpos, rstr} <= mem[raddr];
  end

endmodule

// File: hdl/oms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oms_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module oms_div #(
  parameter int DVD_W = 58,
  parameter int DVS_W = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, quot[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      done <= 1'b0;
      cnt  <= CW'(DVD_W);
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      quot <= dividend;
      rem  <= '0;
    end else if (cnt != '0) begin
      quot <= {quot[DVD_W-2:0], ge};
      rem  <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
    end
  end

endmodule

// File: hdl/onset_meter_and_swing_analyzer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onset_meter_and_swing_analyzer_core
// Keeps a bounded onset history; per onset rescans it to score the meter
// and to average off-beat phase into a swing amount.
//
//   channel  dir  beat contents
//   onset    in   onset_pos, onset_strength, beat_period
//   result   out  meter_num, swing, meter_updated
//
// Per onset the one shared bit-serial divider runs up to twice per history
// entry (beat bin, phase) and once for the swing. The bin pass runs only
// with 8 or more entries and only for an entry not earlier than the oldest;
// with 4 to 7 entries it is skipped. With no off-beat onset the swing
// division is skipped. With fewer than 4 entries or a zero period no
// rescan is done and the onset goes straight to its result load.
// Reset clears state, count, head, meter (four) and result valid; history is
// not cleared.
// onset.ready is high only while idle; a result waiting on result.ready
// does not block the next onset, only its final load.
// ----------------------------------------------------------------------------
module onset_meter_and_swing_analyzer_core
  import oms_pkg::*;
#(
  parameter int HISTORY_DEPTH = 128,
  parameter int BEAT_BINS     = 64
) (
  input logic         clk,
  input logic         rst,
  oms_onset_if.sink   onset,
  oms_result_if.source result
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int DVD_W  = ((49 + CNT_W) > 58) ? (49 + CNT_W) : 58;
  localparam int DVS_W  = 33 + CNT_W;
  localparam int ACC_W  = STR_W + CNT_W;
  localparam int SUM_W  = PER_W + CNT_W;

  state_t state, state_next;
  div_sel_t div_sel;

  logic [AW-1:0]    head, ptr, waddr, ptr_inc;
  logic [CNT_W-1:0] count, count_next, idx;
  logic [CNT_W:0]   wsum;
  logic [PER_W-1:0] period;
  logic [POS_W-1:0] first, first_v, ent_pos, mem_pos;
  logic [STR_W-1:0] ent_str, mem_str;
  logic             meter_ok, accept, out_load, div_start, div_done, use_bin;
  logic [ACC_W-1:0] acc_tot, acc2, acc3, acc4, acc6, best_sum;
  logic [SUM_W-1:0] ssum, den;
  logic [CNT_W-1:0] ncnt;
  logic [SUM_W:0]   mag;
  logic             neg;
  logic signed [SWING_W-1:0] swing_val, swing_sat;
  logic [METER_W-1:0] meter_reg, best;
  logic             last;
  logic [DVD_W-1:0] div_dvd, quot;
  logic [DVS_W-1:0] div_dvs, rem;
  logic [BIN_W-1:0] bin;
  logic             bin_ok;
  logic [PER_W+3:0] r10, p3, p7;

  assign accept  = onset.valid && onset.ready;
  assign wsum    = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign waddr   = (count < CNT_W'(HISTORY_DEPTH)) ?
                   ((wsum >= (CNT_W+1)'(HISTORY_DEPTH)) ?
                    AW'(wsum - (CNT_W+1)'(HISTORY_DEPTH)) : AW'(wsum)) : head;
  assign count_next = (count < CNT_W'(HISTORY_DEPTH)) ? count + 1'b1 : count;
  assign ptr_inc = (ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign first_v = (idx == '0) ? mem_pos : first;
  assign last    = (idx == count - 1'b1);

  oms_hist_mem #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wpos  (onset.onset_pos),
    .wstr  (onset.onset_strength),
    .raddr (ptr),
    .rpos  (mem_pos),
    .rstr  (mem_str)
  );

  always_comb begin
    case (div_sel)
      DSEL_BIN: begin
        div_dvd = DVD_W'({POS_W'(mem_pos - first_v), 9'b0}) + DVD_W'(period);
        div_dvs = DVS_W'({period, 1'b0});
      end
      DSEL_PHASE: begin
        div_dvd = DVD_W'({((state == ST_LAT) ? mem_pos : ent_pos), 8'b0});
        div_dvs = DVS_W'(period);
      end
      DSEL_SWING: begin
        div_dvd = DVD_W'({mag, 16'b0}) + DVD_W'(den);
        div_dvs = DVS_W'({den, 1'b0});
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  oms_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // beat bin and phase tests on the divider result
  assign bin    = quot[BIN_W-1:0];
  assign bin_ok = quot < DVD_W'(BEAT_BINS);
  assign r10    = (PER_W+4)'(rem[PER_W-1:0]) * 4'd10;
  assign p3     = (PER_W+4)'(period) * 4'd3;
  assign p7     = (PER_W+4)'(period) * 4'd7;

  // meter pick: first strict maximum in order 2, 3, 4, 6
  always_comb begin
    best     = METER_TWO;
    best_sum = acc2;
    if (acc3 > best_sum) begin
      best     = METER_THREE;
      best_sum = acc3;
    end
    if (acc4 > best_sum) begin
      best     = METER_FOUR;
      best_sum = acc4;
    end
    if (acc6 > best_sum) begin
      best     = METER_SIX;
      best_sum = acc6;
    end
  end

  always_comb begin
    if (neg) begin
      swing_sat = (quot >= DVD_W'(32768)) ? SWING_MIN : -$signed(SWING_W'(quot));
    end else begin
      swing_sat = (quot >= DVD_W'(32767)) ? SWING_MAX : $signed(SWING_W'(quot));
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (count_next >= CNT_W'(MIN_SWING_ENTRIES) &&
                        onset.beat_period != '0) ? ST_RD : ST_FIN;
        end
      end
      ST_RD:      state_next = ST_LAT;
      ST_LAT:     state_next = use_bin ? ST_DIV_BIN : ST_DIV_PH;
      ST_DIV_BIN: if (div_done) state_next = ST_DIV_PH;
      ST_DIV_PH:  if (div_done) state_next = last ? ST_SW_MUL : ST_RD;
      ST_SW_MUL:  state_next = (ncnt == '0) ? ST_FIN : ST_SW_SUB;
      ST_SW_SUB:  state_next = ST_SW_GO;
      ST_SW_GO:   state_next = ST_SW_DIV;
      ST_SW_DIV:  if (div_done) state_next = ST_FIN;
      ST_FIN:     if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    use_bin     = meter_ok && (mem_pos >= first_v);
    onset.ready = (state == ST_IDLE);
    out_load    = (state == ST_FIN) && (!result.valid || result.ready);
    div_start   = 1'b0;
    div_sel     = DSEL_PHASE;
    case (state)
      ST_LAT: begin
        div_start = 1'b1;
        div_sel   = use_bin ? DSEL_BIN : DSEL_PHASE;
      end
      ST_DIV_BIN: div_start = div_done;
      ST_SW_GO: begin
        div_start = 1'b1;
        div_sel   = DSEL_SWING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      meter_reg <= METER_FOUR;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
        if (count == CNT_W'(HISTORY_DEPTH)) begin
          head <= (head == AW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
        end
      end
      if (out_load) begin
        result.valid <= 1'b1;
        if (meter_ok && acc_tot != '0) begin
          meter_reg <= best;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          period    <= onset.beat_period;
          meter_ok  <= count_next >= CNT_W'(MIN_METER_ENTRIES) && onset.beat_period != '0;
          ptr       <= (count == CNT_W'(HISTORY_DEPTH)) ?
                       ((head == AW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1) : head;
          idx       <= '0;
          acc_tot   <= '0;
          acc2      <= '0;
          acc3      <= '0;
          acc4      <= '0;
          acc6      <= '0;
          ssum      <= '0;
          ncnt      <= '0;
          swing_val <= '0;
        end
      end
      ST_LAT: begin
        if (idx == '0) begin
          first <= mem_pos;
        end
        ent_pos <= mem_pos;
        ent_str <= mem_str;
      end
      ST_DIV_BIN: begin
        if (div_done && bin_ok) begin
          acc_tot <= acc_tot + ACC_W'(ent_str);
          if (!bin[0]) acc2 <= acc2 + ACC_W'(ent_str);
          if (mod3_zero(bin)) acc3 <= acc3 + ACC_W'(ent_str);
          if (bin[1:0] == 2'b00) acc4 <= acc4 + ACC_W'(ent_str);
          if (!bin[0] && mod3_zero(bin)) acc6 <= acc6 + ACC_W'(ent_str);
        end
      end
      ST_DIV_PH: begin
        if (div_done) begin
          if (r10 > p3 && r10 < p7) begin
            ssum <= ssum + SUM_W'(rem[PER_W-1:0]);
            ncnt <= ncnt + 1'b1;
          end
          idx <= idx + 1'b1;
          ptr <= ptr_inc;
        end
      end
      ST_SW_MUL: den <= SUM_W'(ncnt) * SUM_W'(period);
      ST_SW_SUB: begin
        if ({ssum, 1'b0} >= (SUM_W+1)'(den)) begin
          neg <= 1'b0;
          mag <= {ssum, 1'b0} - (SUM_W+1)'(den);
        end else begin
          neg <= 1'b1;
          mag <= (SUM_W+1)'(den) - {ssum, 1'b0};
        end
      end
      ST_SW_DIV: if (div_done) swing_val <= swing_sat;
      default: ;
    endcase
    if (out_load) begin
      result.swing         <= swing_val;
      result.meter_updated <= meter_ok && acc_tot != '0;
      result.meter_num     <= (meter_ok && acc_tot != '0) ? best : meter_reg;
    end
  end

endmodule

// File: verif/onset_meter_and_swing_analyzer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onset_meter_and_swing_analyzer_core_test
// Drives onsets into the meter / swing core with random gaps and stalls and
// checks each meter numerator, swing amount and update flag against a
// predictor that rescans its own copy of the onset history.
// ----------------------------------------------------------------------------
module onset_meter_and_swing_analyzer_core_test;
  import oms_pkg::*;

  localparam int DEPTH = 128;
  localparam int BINS = 64;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int LONG_HOLD = 8000;

  typedef struct {
    logic [METER_W-1:0]        meter_num;
    logic signed [SWING_W-1:0] swing;
    logic                      meter_updated;
  } meter_result_t;

  class meter_scoreboard;
    logic [POS_W-1:0] pos_hist[DEPTH];
    logic [STR_W-1:0] str_hist[DEPTH];
    int               fill;
    logic [METER_W-1:0] meter;
    meter_result_t    pending[$];
    int               fails;

    function void clear();
      fill = 0;
      meter = METER_FOUR;
      fails = 0;
      pending.delete();
    endfunction

    function bit score_meter(bit [63:0] per);
      bit [63:0] hist_bins[BINS];
      bit [63:0] first, d, bin, total, down, best_sum;
      logic [METER_W-1:0] cands[4];
      logic [METER_W-1:0] best;
      bit have;
      if (fill < MIN_METER_ENTRIES || per == 0) return 0;
      cands = '{METER_TWO, METER_THREE, METER_FOUR, METER_SIX};
      foreach (hist_bins[i]) hist_bins[i] = 0;
      first = pos_hist[0];
      for (int i = 0; i < fill; i++) begin
        if (64'(pos_hist[i]) < first) continue;  // earlier onset lies past every bin
        d = 64'(pos_hist[i]) - first;
        bin = (2 * d * 256 + per) / (2 * per);
        if (bin < BINS) hist_bins[bin] += str_hist[i];
      end
      total = 0;
      foreach (hist_bins[i]) total += hist_bins[i];
      if (total == 0) return 0;
      have = 0;
      best_sum = 0;
      best = METER_FOUR;
      for (int k = 0; k < 4; k++) begin
        down = 0;
        for (int i = 0; i < BINS; i += int'(cands[k])) down += hist_bins[i];
        if (!have || down > best_sum) begin
          have = 1;
          best_sum = down;
          best = cands[k];
        end
      end
      meter = best;
      return 1;
    endfunction

    function logic signed [SWING_W-1:0] score_swing(bit [63:0] per);
      bit [63:0] sum, n, r, den, mag, q;
      longint signed num;
      if (fill < MIN_SWING_ENTRIES || per == 0) return 0;
      sum = 0;
      n = 0;
      for (int i = 0; i < fill; i++) begin
        r = (64'(pos_hist[i]) << 8) % per;
        if (10 * r > 3 * per && 10 * r < 7 * per) begin
          sum += r;
          n++;
        end
      end
      if (n == 0) return 0;
      den = n * per;
      num = longint'(2 * sum) - longint'(den);
      mag = (num < 0) ? 64'(-num) : 64'(num);
      q = (mag * 65536 + den) / (2 * den);
      if (num < 0) return (q >= 32768) ? SWING_MIN : -16'(q);
      return (q >= 32767) ? SWING_MAX : 16'(q);
    endfunction

    function void note_onset(logic [POS_W-1:0] pos, logic [STR_W-1:0] str,
                             logic [PER_W-1:0] per);
      meter_result_t e;
      if (fill < DEPTH) begin
        pos_hist[fill] = pos;
        str_hist[fill] = str;
        fill++;
      end else begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          pos_hist[i] = pos_hist[i+1];
          str_hist[i] = str_hist[i+1];
        end
        pos_hist[DEPTH-1] = pos;
        str_hist[DEPTH-1] = str;
      end
      e.meter_updated = score_meter(64'(per));
      e.swing = score_swing(64'(per));
      e.meter_num = meter;
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(meter_result_t got);
      meter_result_t e;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result beat: meter %0d swing %0d upd %0d",
                                  got.meter_num, got.swing, got.meter_updated);
        return;
      end
      e = pending.pop_front();
      if (got.meter_num !== e.meter_num || got.swing !== e.swing ||
          got.meter_updated !== e.meter_updated) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected meter %0d swing %0d upd %0d, got %0d %0d %0d",
                   e.meter_num, e.swing, e.meter_updated,
                   got.meter_num, got.swing, got.meter_updated);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  bit   hold_req;
  meter_scoreboard sb;

  oms_onset_if  onset_ch();
  oms_result_if result_ch();

  onset_meter_and_swing_analyzer_core DUT (
    .clk   (clk),
    .rst   (rst),
    .onset (onset_ch),
    .result(result_ch)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("onset_meter_and_swing_analyzer_core verification failed");
        $finish;
      end
    end
  end

  task automatic send_onset(logic [POS_W-1:0] pos, logic [STR_W-1:0] str,
                            logic [PER_W-1:0] per);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      onset_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    onset_ch.valid <= 1'b1;
    onset_ch.onset_pos <= pos;
    onset_ch.onset_strength <= str;
    onset_ch.beat_period <= per;
    do @(posedge clk); while (!onset_ch.ready);
    sb.note_onset(pos, str, per);
    @(negedge clk);
  endtask

  task automatic drain_results();
    onset_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // result side: random stalls per beat, one long hold when asked
  initial begin
    meter_result_t got;
    int gap;
    result_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        hold_req = 0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      got.meter_num = result_ch.meter_num;
      got.swing = result_ch.swing;
      got.meter_updated = result_ch.meter_updated;
      sb.check_result(got);
    end
  end

  initial begin
    logic [POS_W-1:0] cur;
    logic [PER_W-1:0] per;
    int kind;
    sb = new();
    sb.clear();
    hold_req = 0;
    onset_ch.valid = 1'b0;
    onset_ch.onset_pos = '0;
    onset_ch.onset_strength = '0;
    onset_ch.beat_period = '0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: one beat = 100 samples at period 25600; oldest entry at 1000
    send_onset(48'd1000, 16'h0000, 32'd0);
    send_onset(48'd0, 16'hFFFF, 32'd0);                      // earlier onset
    send_onset(48'hFFFF_FFFF_FFFF, 16'h0000, 32'hFFFF_FFFF); // short history
    send_onset(48'd1100, 16'h0000, 32'd25600);
    send_onset(48'd1200, 16'h0000, 32'd25600);
    send_onset(48'd1300, 16'h0000, 32'd25600);
    send_onset(48'd1400, 16'h0000, 32'd25600);
    send_onset(48'd1500, 16'h0000, 32'd25600);               // all bins zero
    send_onset(48'd1600, 16'h0100, 32'd25600);               // two wins ties
    send_onset(48'd1300, 16'h0800, 32'd25600);
    send_onset(48'd1900, 16'h0800, 32'd25600);               // three wins
    send_onset(48'd2000, 16'h0400, 32'd0);                   // zero period
    send_onset(48'd1150, 16'h0200, 32'd25600);               // off-beat
    send_onset(48'd1240, 16'h0200, 32'd25600);
    send_onset(48'h8000_0000_0000, 16'h8000, 32'hFFFF_FFFF);
    send_onset(48'd1000, 16'hFFFF, 32'd25600);
    send_onset(48'h5555_5555_5555, 16'h5555, 32'hAAAA_AAAA);
    send_onset(48'h2AAA_AAAA_AAAA, 16'hAAAA, 32'h5555_5555);
    send_onset(48'd1000, 16'h0001, 32'd1);
    drain_results();

    // long result hold while onsets keep coming
    hold_req = 1;
    cur = 48'd2000;
    per = 32'd25600;
    for (int i = 0; i < 100; i++) begin
      if (i % 10 == 0) per = 32'(256 * $urandom_range(20, 200));
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_onset(48'({$urandom(), $urandom()}), 16'($urandom()), $urandom());
      end else if (kind == 1) begin
        send_onset(cur, 16'($urandom()), 32'd0);
      end else begin
        // onsets on half-beat grid with small jitter
        cur = cur + 48'((per >> 9) * $urandom_range(1, 2)) + 48'($urandom_range(0, 8));
        send_onset(cur, 16'($urandom()), per);
      end
      if (i == 50) drain_results();
    end
    drain_results();
    repeat (100) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0)
      $display("onset_meter_and_swing_analyzer_core verification clean");
    else
      $display("onset_meter_and_swing_analyzer_core verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/oms_pkg.sv
hdl/oms_onset_if.sv
hdl/oms_result_if.sv
hdl/oms_hist_mem.sv
hdl/oms_div.sv
hdl/onset_meter_and_swing_analyzer_core.sv
verif/onset_meter_and_swing_analyzer_core_test.sv
